@@ hw/rtl/swbm_pkg.sv @@
`timescale 1ns / 1ps

package swbm_pkg;

  // Field widths of the transaction payloads
  localparam int TIME_W    = 32;
  localparam int BYTES_W   = 16;
  localparam int RATE_W    = 20;
  localparam int EXP_W     = 7;
  localparam int SPAN_W    = 16;
  localparam int DIVISOR_W = SPAN_W + 1;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd10;
  localparam logic [CFG_W-1:0] MIN_SPAN_RST = 16'd1;

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  // Saturation limits
  localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
  localparam logic [EXP_W-1:0]  EXPIRED_MAX = {EXP_W{1'b1}};

  typedef struct packed {
    logic               op;
    logic [TIME_W-1:0]  now_time;
    logic [BYTES_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_q8;
    logic [EXP_W-1:0]  expired_count;
    logic              overflow;
  } out_item_t;

  // One stored FIFO entry
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic rd_head;
    logic push;
    logic push_drop;
    logic pop;
    logic span_clear;
    logic span_load;
    logic div_load;
    logic div_step;
    logic fin;
    logic fin_div;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic expire;
    logic span_ok;
    logic div_done;
  } ctl_stat_t;

endpackage

@@ hw/rtl/swbm_ram.sv @@
`timescale 1ns / 1ps

module swbm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/swbm_datapath.sv @@
`timescale 1ns / 1ps

module swbm_datapath #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swbm_pkg::in_item_t                 in_item,
  input  logic                               cfg_we,
  input  logic [swbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swbm_pkg::CFG_W-1:0]         cfg_wdata,
  input  swbm_pkg::ctl_cmd_t                 cmd,
  output swbm_pkg::ctl_stat_t                stat,
  output logic                               out_valid,
  output swbm_pkg::out_item_t                out_item
);

  import swbm_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = $clog2(FIFO_DEPTH * ((1 << BYTES_W) - 1) + 1);
  localparam int QUO_W  = SUM_W - 2;
  localparam int SAT_W  = (QUO_W > RATE_W) ? QUO_W : RATE_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // Configuration
  logic [CFG_W-1:0] window_r, window_nxt;
  logic [CFG_W-1:0] min_span_r, min_span_nxt;

  // FIFO control
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Transaction working registers
  in_item_t             item_r, item_nxt;
  logic [EXP_W-1:0]     expired_r, expired_nxt;
  logic [SPAN_W-1:0]    span_r, span_nxt;
  logic [DIVISOR_W-1:0] divisor_r, divisor_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  // Result
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  entry_t               rd_entry;
  entry_t               wr_entry;
  logic [TIME_W-1:0]    age;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_diff;
  logic                 take;
  logic [SAT_W-1:0]     quo_ext;
  logic [RATE_W-1:0]    rate_sat;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Entry storage: time stamp and byte count side by side
  assign wr_entry.stamp = item_r.now_time;
  assign wr_entry.bytes = item_r.byte_count;

  swbm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.push | cmd.push_drop),
    .waddr (tail_r),
    .wdata (wr_entry),
    .re    (cmd.rd_head),
    .raddr (head_r),
    .rdata (rd_entry)
  );

  // Age of the front entry, wrapping
  assign age = item_r.now_time - rd_entry.stamp;

  // One restoring division step
  assign rem_sh   = {rem_r, quo_r[QUO_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor_r};
  assign take     = (rem_sh >= {1'b0, divisor_r});

  // Clamp the quotient to the rate field
  assign quo_ext  = SAT_W'(quo_r);
  assign rate_sat = (quo_ext > SAT_W'(RATE_MAX)) ? RATE_MAX : quo_ext[RATE_W-1:0];

  // Status back to the controller
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CNT_FULL);
  assign stat.expire   = (age > TIME_W'(window_r));
  assign stat.span_ok  = (span_r >= min_span_r);
  assign stat.div_done = (step_r == '0);

  // Configuration writes
  always_comb begin
    window_nxt   = window_r;
    min_span_nxt = min_span_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW:   window_nxt   = cfg_wdata;
        CFG_MIN_SPAN: min_span_nxt = cfg_wdata;
      endcase
    end
  end

  // FIFO pointers, fill count and running sum
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    priority if (cmd.push) begin
      tail_nxt  = ptr_inc(tail_r);
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + SUM_W'(item_r.byte_count);
    end else if (cmd.push_drop) begin
      head_nxt = ptr_inc(head_r);
      tail_nxt = ptr_inc(tail_r);
      sum_nxt  = sum_r - SUM_W'(rd_entry.bytes) + SUM_W'(item_r.byte_count);
    end else if (cmd.pop) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = count_r - 1'b1;
      sum_nxt   = sum_r - SUM_W'(rd_entry.bytes);
    end
  end

  // Capture, expiry count, span and divider
  always_comb begin
    item_nxt    = item_r;
    expired_nxt = expired_r;
    span_nxt    = span_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    if (cmd.capture) begin
      item_nxt    = in_item;
      expired_nxt = '0;
    end
    if (cmd.pop && (expired_r != EXPIRED_MAX)) begin
      expired_nxt = expired_r + 1'b1;
    end
    if (cmd.span_clear) begin
      span_nxt = '0;
    end
    if (cmd.span_load) begin
      span_nxt = age[SPAN_W-1:0];
    end
    // sum / (4 * (span + 1)) = (sum >> 2) / (span + 1)
    priority if (cmd.div_load) begin
      divisor_nxt = {1'b0, span_r} + DIVISOR_W'(1);
      rem_nxt     = '0;
      quo_nxt     = sum_r[SUM_W-1:2];
      step_nxt    = STEP_W'(QUO_W);
    end else if (cmd.div_step) begin
      rem_nxt  = take ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], take};
      step_nxt = step_r - 1'b1;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = cmd.fin;
    out_item_nxt  = out_item_r;
    if (cmd.fin) begin
      out_item_nxt.rate_q8       = cmd.fin_div ? rate_sat : '0;
      out_item_nxt.expired_count = expired_r;
      out_item_nxt.overflow      = cmd.push_drop;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RST;
      min_span_r  <= MIN_SPAN_RST;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      min_span_r  <= min_span_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    expired_r  <= expired_nxt;
    span_r     <= span_nxt;
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("fill count above FIFO depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (head_r == tail_r))
    else $error("head and tail disagree with fill count");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

endmodule

@@ hw/rtl/swbm_ctrl.sv @@
`timescale 1ns / 1ps

module swbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_op,
  input  swbm_pkg::ctl_stat_t  stat,
  output logic                 busy,
  output swbm_pkg::ctl_cmd_t   cmd
);

  import swbm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REC_RD   = 3'd1;
  localparam logic [2:0] S_REC_DROP = 3'd2;
  localparam logic [2:0] S_REC_WR   = 3'd3;
  localparam logic [2:0] S_EV_RD    = 3'd4;
  localparam logic [2:0] S_EV_CHK   = 3'd5;
  localparam logic [2:0] S_EV_SPAN  = 3'd6;
  localparam logic [2:0] S_DIV      = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Sequence one transaction
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (in_op == OP_EVAL) begin
            state_nxt = S_EV_RD;
          end else if (stat.full) begin
            state_nxt = S_REC_RD;
          end else begin
            state_nxt = S_REC_WR;
          end
        end
      end
      S_REC_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_REC_DROP;
      end
      S_REC_DROP: begin
        cmd.push_drop = 1'b1;
        cmd.fin       = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REC_WR: begin
        cmd.push  = 1'b1;
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EV_RD: begin
        if (stat.empty) begin
          cmd.span_clear = 1'b1;
          state_nxt      = S_EV_SPAN;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (stat.expire) begin
          cmd.pop   = 1'b1;
          state_nxt = S_EV_RD;
        end else begin
          cmd.span_load = 1'b1;
          state_nxt     = S_EV_SPAN;
        end
      end
      S_EV_SPAN: begin
        if (stat.span_ok) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.fin     = 1'b1;
          cmd.fin_div = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.push_drop, cmd.pop, cmd.div_load, cmd.div_step}))
    else $error("conflicting datapath updates");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !busy)
    else $error("controller not idle after result");

endmodule

@@ hw/rtl/sliding_window_bandwidth_meter.sv @@
`timescale 1ns / 1ps

// Sliding-window bandwidth meter for one connection. A transaction is taken
// when start is high and busy is low; each transaction yields exactly one
// result, shown on out_item for the single cycle out_valid is high, and the
// receiver cannot stall it. A record that finds the FIFO full displaces the
// oldest entry, which costs one extra read of the entry RAM. An evaluate
// checks the front entries for expiry (up to FIFO_DEPTH of them), each check
// needing one registered read of the entry RAM plus a compare, and then runs
// the bit-serial divider only when the span reaches the minimum; the
// divider retires one quotient bit per cycle, and its quotient is 20 bits
// wide for a 64-entry FIFO. Result items are returned in order, one at a
// time; the next transaction can be taken in the cycle its result appears.
// The entry RAM needs no clearing after reset. Configuration must be written
// only while busy is low; the block itself does not enforce this.
module sliding_window_bandwidth_meter #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  swbm_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output swbm_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [swbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swbm_pkg::CFG_W-1:0]       cfg_wdata
);

  import swbm_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer
  swbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // FIFO, running sum, divider and result register
  swbm_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ verif/tb_sliding_window_bandwidth_meter.sv @@
`timescale 1ns / 1ps

module tb_sliding_window_bandwidth_meter;
  import swbm_pkg::*;

  localparam int DEPTH         = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 500;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_e;

  typedef struct packed {
    act_kind_e            kind;
    in_item_t             item;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    logic [4:0]           gap;
  } action_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Stimulus plan and results still owed by the block
  action_t   stim_plan[$];
  out_item_t pending_reports[$];

  // Meter model state
  logic [TIME_W-1:0]  stamp_mem[DEPTH];
  logic [BYTES_W-1:0] bytes_mem[DEPTH];
  int                 head_idx;
  int                 tail_idx;
  int                 fill;
  longint unsigned    byte_sum;
  logic [CFG_W-1:0]   window_cfg;
  logic [CFG_W-1:0]   min_span_cfg;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gen_items      = 0;
  int idle_count     = 0;
  int settle_count   = 0;

  sliding_window_bandwidth_meter #(
    .FIFO_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop the oldest entry and take its bytes off the sum
  function void retire_oldest();
    byte_sum = byte_sum - bytes_mem[head_idx];
    head_idx = (head_idx + 1) % DEPTH;
    fill     = fill - 1;
  endfunction

  // Advance the meter model by one transaction and return its report
  function out_item_t meter_predict(input in_item_t it);
    out_item_t         res;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] span;
    longint unsigned   quo;
    res = '0;
    if (it.op == OP_RECORD) begin
      if (fill == DEPTH) begin
        retire_oldest();
        res.overflow = 1'b1;
      end
      stamp_mem[tail_idx] = it.now_time;
      bytes_mem[tail_idx] = it.byte_count;
      tail_idx = (tail_idx + 1) % DEPTH;
      fill     = fill + 1;
      byte_sum = byte_sum + it.byte_count;
    end else begin
      // Expire front entries outside the window (wrapping age)
      while (fill > 0) begin
        age = it.now_time - stamp_mem[head_idx];
        if (age <= {16'd0, window_cfg}) break;
        retire_oldest();
        if (res.expired_count != EXPIRED_MAX) res.expired_count = res.expired_count + 1'b1;
      end
      oldest = (fill > 0) ? stamp_mem[head_idx] : it.now_time;
      span   = it.now_time - oldest;
      if (span >= {16'd0, min_span_cfg}) begin
        quo = byte_sum / (64'd4 * (64'(span) + 64'd1));
        res.rate_q8 = (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
      end
    end
    return res;
  endfunction

  // Drive transactions and register writes from the plan
  always @(posedge clk) begin : drive_proc
    logic                 nxt_start;
    in_item_t             nxt_item;
    logic                 nxt_we;
    logic [CFG_IDX_W-1:0] nxt_idx;
    logic [CFG_W-1:0]     nxt_data;
    action_t              act;
    if (!rst_n) begin
      window_cfg   = WINDOW_RST;
      min_span_cfg = MIN_SPAN_RST;
      head_idx     = 0;
      tail_idx     = 0;
      fill         = 0;
      byte_sum     = 0;
      idle_count   = 0;
      settle_count = 0;
      start     <= 1'b0;
      cfg_we    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW) window_cfg = cfg_wdata;
        else if (cfg_index == CFG_MIN_SPAN) min_span_cfg = cfg_wdata;
      end
      if (start && !busy) pending_reports.push_back(meter_predict(in_item));

      // Hold the transaction until the block takes it
      nxt_start = start && busy;
      nxt_item  = in_item;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_index;
      nxt_data  = cfg_wdata;
      if (!nxt_start && stim_plan.size() > 0) begin
        act = stim_plan[0];
        case (act.kind)
          ACT_ITEM: begin
            if (idle_count < act.gap) begin
              idle_count = idle_count + 1;
            end else begin
              idle_count = 0;
              nxt_start  = 1'b1;
              nxt_item   = act.item;
              void'(stim_plan.pop_front());
            end
          end
          ACT_CFG: begin
            nxt_we   = 1'b1;
            nxt_idx  = act.index;
            nxt_data = act.value;
            void'(stim_plan.pop_front());
          end
          default: begin
            // Wait until every report is in and the block sits idle
            if (pending_reports.size() == 0 && !busy && !start)
              settle_count = settle_count + 1;
            else
              settle_count = 0;
            if (settle_count >= 4) begin
              settle_count = 0;
              void'(stim_plan.pop_front());
            end
          end
        endcase
      end
      start     <= nxt_start;
      in_item   <= nxt_item;
      cfg_we    <= nxt_we;
      cfg_index <= nxt_idx;
      cfg_wdata <= nxt_data;
    end
  end

  // Compare each report against the oldest prediction
  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected report: rate %0d expired %0d overflow %0d",
                   out_item.rate_q8, out_item.expired_count, out_item.overflow);
      end else begin
        want = pending_reports.pop_front();
        if (out_item.rate_q8 !== want.rate_q8 ||
            out_item.expired_count !== want.expired_count ||
            out_item.overflow !== want.overflow) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display({"mismatch: expected rate %0d expired %0d overflow %0d,",
                      " got rate %0d expired %0d overflow %0d"},
                     want.rate_q8, want.expired_count, want.overflow,
                     out_item.rate_q8, out_item.expired_count, out_item.overflow);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_item(input logic op, input logic [TIME_W-1:0] t,
                          input logic [BYTES_W-1:0] nbytes, input int gap);
    action_t act;
    act                 = '0;
    act.kind            = ACT_ITEM;
    act.item.op         = op;
    act.item.now_time   = t;
    act.item.byte_count = nbytes;
    act.gap             = gap[4:0];
    stim_plan.push_back(act);
  endtask

  task automatic add_drain();
    action_t act;
    act      = '0;
    act.kind = ACT_DRAIN;
    stim_plan.push_back(act);
  endtask

  // Register writes only go in once the block has drained
  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    action_t act;
    add_drain();
    act       = '0;
    act.kind  = ACT_CFG;
    act.index = idx;
    act.value = val;
    stim_plan.push_back(act);
  endtask

  // One random phase: fresh settings, then mostly realistic traffic
  task automatic add_phase(input int n, input bit quiet);
    int                 win;
    int                 mspan;
    int                 k;
    int                 j;
    int                 r;
    int                 gap;
    int                 flood;
    bit                 idling;
    logic               op;
    logic [TIME_W-1:0]  t;
    logic [BYTES_W-1:0] nbytes;
    case ($urandom_range(0, 5))
      0:       win = 1;
      1:       win = 10;
      2:       win = 65535;
      3:       win = 0;
      default: win = $urandom_range(2, 300);
    endcase
    case ($urandom_range(0, 6))
      0:       mspan = 0;
      1:       mspan = 1;
      2:       mspan = 65535;
      3:       mspan = $urandom_range(0, win);
      4:       mspan = $urandom_range(0, 65535);
      default: mspan = $urandom_range(0, (win > 20) ? 20 : win);
    endcase
    add_cfg(CFG_WINDOW, win[CFG_W-1:0]);
    add_cfg(CFG_MIN_SPAN, mspan[CFG_W-1:0]);
    t      = $urandom();
    idling = 1'b0;
    for (k = 0; k < n; k++) begin
      if (k % 16 == 0) idling = !quiet && ($urandom_range(0, 2) != 0);
      gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;

      // Advance time: mostly small steps, sometimes jumps back or anywhere
      r = $urandom_range(0, 99);
      if (r < 70)      t = t + $urandom_range(0, 2);
      else if (r < 88) t = t + $urandom_range(0, win + 2);
      else if (r < 94) t = t - $urandom_range(1, 50);
      else             t = $urandom();

      r = $urandom_range(0, 99);
      if (r < 10)      nbytes = '0;
      else if (r < 20) nbytes = '1;
      else             nbytes = BYTES_W'($urandom_range(0, 65535));

      op = ($urandom_range(0, 99) < 65) ? OP_RECORD : OP_EVAL;
      add_item(op, t, nbytes, gap);
      gen_items = gen_items + 1;

      // Occasionally flood the FIFO past full
      if ($urandom_range(0, 39) == 0) begin
        flood = $urandom_range(60, 72);
        for (j = 0; j < flood; j++) begin
          if ($urandom_range(0, 3) == 0) t = t + 1;
          add_item(OP_RECORD, t, BYTES_W'($urandom_range(0, 65535)), quiet ? 0 : gap);
        end
        gen_items = gen_items + flood;
      end

      // Pause now and then until every report is back
      if ($urandom_range(0, 99) == 0) add_drain();
    end
  endtask

  initial begin
    // Empty FIFO, boundary of the minimum span, expiry of all entries
    add_item(OP_EVAL, 32'd0, 16'd0, 0);
    add_item(OP_RECORD, 32'd0, 16'd0, 0);
    add_item(OP_RECORD, 32'd0, 16'hFFFF, 0);
    add_item(OP_EVAL, 32'd0, 16'd0, 0);
    add_item(OP_EVAL, 32'd5, 16'hFFFF, 0);
    add_item(OP_EVAL, 32'd11, 16'd0, 0);

    // Zero minimum span: empty evaluate and a same-timestamp rate
    add_cfg(CFG_MIN_SPAN, 16'd0);
    add_item(OP_EVAL, 32'd50, 16'd0, 0);
    add_item(OP_RECORD, 32'd100, 16'd4000, 0);
    add_item(OP_EVAL, 32'd100, 16'd0, 0);

    // Zero window: only entries stamped exactly now survive
    add_cfg(CFG_WINDOW, 16'd0);
    add_item(OP_RECORD, 32'd200, 16'd1, 0);
    add_item(OP_RECORD, 32'd201, 16'd2, 0);
    add_item(OP_EVAL, 32'd201, 16'd0, 0);

    // Entry stamped in the future expires
    add_item(OP_RECORD, 32'd500, 16'd7, 0);
    add_item(OP_EVAL, 32'd400, 16'd0, 0);

    // Time wraps past the top of the counter
    add_cfg(CFG_WINDOW, 16'd10);
    add_item(OP_RECORD, 32'hFFFF_FFFF, 16'hFFFF, 0);
    add_item(OP_EVAL, 32'd3, 16'd0, 0);

    // Widest window and span
    add_cfg(CFG_WINDOW, 16'hFFFF);
    add_cfg(CFG_MIN_SPAN, 16'hFFFF);
    add_item(OP_RECORD, 32'h8000_0000, 16'hAAAA, 0);
    add_item(OP_EVAL, 32'h8000_FFFE, 16'h5555, 0);
    add_item(OP_EVAL, 32'h8000_FFFF, 16'd0, 0);

    // Random phases, the last one without idle gaps
    while (gen_items < RANDOM_ITEMS - 160) add_phase($urandom_range(40, 80), 1'b0);
    add_phase(60, 1'b1);

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the plan to run out and every report to arrive
    @(negedge clk);
    while (stim_plan.size() != 0 || start || pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
